FILE: rtl/core/line_edit_input_fifo_defines.svh
// Assertion macros for the line editing input FIFO.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef LINE_EDIT_INPUT_FIFO_DEFINES_SVH
`define LINE_EDIT_INPUT_FIFO_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LEI_ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line_edit_input_fifo: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LEI_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line_edit_input_fifo: next-cycle check failed");

`endif

FILE: rtl/core/lei_pkg.sv
// Shared types and constants of the line editing input FIFO.
// Used by the front end, back end, result queue and top module; depends on nothing.
package lei_pkg;

   localparam int DEPTH_DEFAULT    = 512;
   localparam int MAX_READ_DEFAULT = 64;

   // Command queue between front and back, and result queue at the output.
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 4;

   localparam logic [7:0] BACKSPACE_CODE = 8'h08;
   localparam logic [7:0] NEWLINE_CODE   = 8'h0A;

   typedef enum logic [2:0] {
      KIND_STORED    = 3'd0,
      KIND_BACKSPACE = 3'd1,
      KIND_DROPPED   = 3'd2,
      KIND_DATA      = 3'd3,
      KIND_EMPTY     = 3'd4,
      KIND_ZERO_LEN  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      OP_BACKSPACE,
      OP_APPEND,
      OP_READ_ZERO,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  char_val;
      logic [6:0]  read_len;
      logic        newline;
   } cmd_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [9:0]  fill_level;
      logic        line_ready;
      logic        last;
   } rsp_type;

endpackage

FILE: rtl/core/line_edit_input_fifo.sv
// Line editing input FIFO: console receive buffer with echo and backspace.
// A single-result transaction passes the command queue, the result stage and the result
// queue to the output ports; a read holds off later commands until its last byte issues.
// Throughput: character transactions 1 per cycle and read data one byte per cycle from
// the back-end sequencer and the store read port, both while the result queue has room.
// Reset (synchronous): buffer empty, line flag clear, both queues empty.
`include "line_edit_input_fifo_defines.svh"

module line_edit_input_fifo #(
   parameter int DEPTH    = lei_pkg::DEPTH_DEFAULT,
   parameter int MAX_READ = lei_pkg::MAX_READ_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       req_mode,
   input  logic [7:0] req_char_in,
   input  logic [6:0] req_read_len,
   output logic       empty,
   input  logic       pop,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [9:0] rsp_fill_level,
   output logic       rsp_line_ready,
   output logic       rsp_last
);

   lei_pkg::cmd_type                        cmd;
   logic                                    cmd_valid;
   logic                                    cmd_pop;
   logic                                    rsp_push;
   lei_pkg::rsp_type                        rsp_in;
   lei_pkg::rsp_type                        rsp_dout;
   logic [$clog2(lei_pkg::RSP_DEPTH+1)-1:0] rsp_occ;

   lei_front #(
      .MAX_READ(MAX_READ)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .mode     (req_mode),
      .char_in  (req_char_in),
      .read_len (req_read_len),
      .cmd_valid(cmd_valid),
      .cmd_pop  (cmd_pop),
      .cmd      (cmd)
   );

   lei_back #(
      .DEPTH(DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop),
      .rsp_occ  (rsp_occ),
      .rsp_push (rsp_push),
      .rsp_out  (rsp_in)
   );

   lei_rsp_fifo u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .push (rsp_push),
      .din  (rsp_in),
      .occ  (rsp_occ),
      .empty(empty),
      .pop  (pop),
      .dout (rsp_dout)
   );

   assign rsp_kind       = rsp_dout.kind;
   assign rsp_data_byte  = rsp_dout.data_byte;
   assign rsp_fill_level = rsp_dout.fill_level;
   assign rsp_line_ready = rsp_dout.line_ready;
   assign rsp_last       = rsp_dout.last;

   `LEI_ASSERT_IMPLIES(a_rsp_no_overflow, clock, reset, rsp_push,
                       rsp_occ < lei_pkg::RSP_DEPTH)
   `LEI_ASSERT_IMPLIES(a_empty_read_result, clock, reset,
                       !empty && rsp_dout.kind == lei_pkg::KIND_EMPTY,
                       !rsp_dout.line_ready && rsp_dout.fill_level == 10'd0 && rsp_dout.last)
   `LEI_ASSERT_IMPLIES(a_fill_bounded, clock, reset, !empty,
                       32'(rsp_dout.fill_level) <= DEPTH)
   `LEI_ASSERT_NEXT(a_single_drains, clock, reset,
                    pop && !empty && rsp_occ == 1 && !rsp_push, empty)

endmodule

FILE: rtl/core/lei_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; depends on nothing.
module lei_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/lei_front.sv
// Front end: accepts input transactions, classifies them into commands
// and holds them in a short queue for the back end. Depends on lei_pkg.
module lei_front #(
   parameter int MAX_READ = lei_pkg::MAX_READ_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic             mode,
   input  logic [7:0]       char_in,
   input  logic [6:0]       read_len,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output lei_pkg::cmd_type cmd
);

   localparam int PW = $clog2(lei_pkg::CMD_DEPTH);
   localparam int CW = $clog2(lei_pkg::CMD_DEPTH + 1);

   lei_pkg::cmd_type entry_ff [lei_pkg::CMD_DEPTH];
   lei_pkg::cmd_type cmd_new;
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             accept;
   logic             take;

   always_comb begin
      cmd_new.char_val = char_in;
      cmd_new.newline  = (char_in == lei_pkg::NEWLINE_CODE);
      cmd_new.read_len = (read_len > 7'(MAX_READ)) ? 7'(MAX_READ) : read_len;
      if (mode) begin
         cmd_new.op = (read_len == 7'd0) ? lei_pkg::OP_READ_ZERO : lei_pkg::OP_READ;
      end else begin
         cmd_new.op = (char_in == lei_pkg::BACKSPACE_CODE) ? lei_pkg::OP_BACKSPACE
                                                           : lei_pkg::OP_APPEND;
      end
   end

   assign full      = (count_ff == CW'(lei_pkg::CMD_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign accept    = push && !full;
   assign take      = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == PW'(lei_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PW'(lei_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !accept) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

FILE: rtl/core/lei_back.sv
// Back end: executes commands against the circular byte store and issues
// results into a registered result stage. Depends on lei_pkg and lei_ram.
module lei_back #(
   parameter int DEPTH = lei_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  cmd_valid,
   input  lei_pkg::cmd_type                      cmd,
   output logic                                  cmd_pop,
   input  logic [$clog2(lei_pkg::RSP_DEPTH+1)-1:0] rsp_occ,
   output logic                                  rsp_push,
   output lei_pkg::rsp_type                      rsp_out
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam int SW   = AW + 1;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    head_ff, head_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             newline_ff, newline_in;
   logic [6:0]       rem_ff, rem_in;
   logic             stg_valid_ff, stg_valid_in;
   logic             stg_ram_ff, stg_ram_in;
   lei_pkg::rsp_type stg_rsp_ff, stg_rsp_in;

   logic [SW-1:0]    tail_sum;
   logic [SW-1:0]    tail_pos;
   logic [AW-1:0]    head_next;
   logic             store_full;
   logic             can_issue;
   logic             ram_we;
   logic             ram_re;
   logic [7:0]       ram_rdata;

   assign tail_sum   = SW'(head_ff) + SW'(count_ff);
   assign tail_pos   = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
   assign head_next  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign store_full = (count_ff == CNTW'(DEPTH));
   // Issue only when the result queue has room for the staged result too.
   assign can_issue  = (32'(rsp_occ) + 32'(stg_valid_ff)) < lei_pkg::RSP_DEPTH;

   lei_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(tail_pos[AW-1:0]),
      .wdata(cmd.char_val),
      .re   (ram_re),
      .raddr(head_ff),
      .rdata(ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      newline_in   = newline_ff;
      rem_in       = rem_ff;
      stg_valid_in = 1'b0;
      stg_ram_in   = 1'b0;
      stg_rsp_in   = stg_rsp_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && can_issue) begin
               cmd_pop = 1'b1;
               stg_rsp_in.data_byte = cmd.char_val;
               stg_rsp_in.last      = 1'b1;
               case (cmd.op)
                  lei_pkg::OP_BACKSPACE: begin
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                     stg_rsp_in.kind = lei_pkg::KIND_BACKSPACE;
                     stg_valid_in    = 1'b1;
                  end
                  lei_pkg::OP_APPEND: begin
                     if (!store_full) begin
                        ram_we          = 1'b1;
                        count_in        = count_ff + 1'b1;
                        stg_rsp_in.kind = lei_pkg::KIND_STORED;
                     end else begin
                        stg_rsp_in.kind = lei_pkg::KIND_DROPPED;
                     end
                     if (cmd.newline) begin
                        newline_in = 1'b1;
                     end
                     stg_valid_in = 1'b1;
                  end
                  lei_pkg::OP_READ_ZERO: begin
                     stg_rsp_in.kind      = lei_pkg::KIND_ZERO_LEN;
                     stg_rsp_in.data_byte = 8'h00;
                     stg_valid_in         = 1'b1;
                  end
                  lei_pkg::OP_READ: begin
                     if (count_ff == '0) begin
                        // A read of an empty buffer does not wait; it consumes the line flag.
                        newline_in           = 1'b0;
                        stg_rsp_in.kind      = lei_pkg::KIND_EMPTY;
                        stg_rsp_in.data_byte = 8'h00;
                        stg_valid_in         = 1'b1;
                     end else begin
                        rem_in   = (32'(count_ff) < 32'(cmd.read_len)) ? 7'(count_ff)
                                                                       : cmd.read_len;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
               stg_rsp_in.fill_level = 10'(count_in);
               stg_rsp_in.line_ready = newline_in;
            end
         end
         ST_READ: begin
            if (can_issue) begin
               ram_re                = 1'b1;
               head_in               = head_next;
               count_in              = count_ff - 1'b1;
               rem_in                = rem_ff - 1'b1;
               stg_valid_in          = 1'b1;
               stg_ram_in            = 1'b1;
               stg_rsp_in.kind       = lei_pkg::KIND_DATA;
               stg_rsp_in.data_byte  = 8'h00;
               stg_rsp_in.fill_level = 10'(count_in);
               stg_rsp_in.line_ready = newline_ff;
               stg_rsp_in.last       = (rem_ff == 7'd1);
               if (rem_ff == 7'd1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         newline_ff   <= 1'b0;
         rem_ff       <= '0;
         stg_valid_ff <= 1'b0;
         stg_ram_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         newline_ff   <= newline_in;
         rem_ff       <= rem_in;
         stg_valid_ff <= stg_valid_in;
         stg_ram_ff   <= stg_ram_in;
      end
      stg_rsp_ff <= stg_rsp_in;
   end

   assign rsp_push = stg_valid_ff;

   always_comb begin
      rsp_out = stg_rsp_ff;
      if (stg_ram_ff) begin
         rsp_out.data_byte = ram_rdata;
      end
   end

endmodule

FILE: rtl/core/lei_rsp_fifo.sv
// Result queue: holds finished results until the consumer pops them.
// Depends on lei_pkg.
module lei_rsp_fifo (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    push,
   input  lei_pkg::rsp_type                        din,
   output logic [$clog2(lei_pkg::RSP_DEPTH+1)-1:0] occ,
   output logic                                    empty,
   input  logic                                    pop,
   output lei_pkg::rsp_type                        dout
);

   localparam int PW = $clog2(lei_pkg::RSP_DEPTH);
   localparam int CW = $clog2(lei_pkg::RSP_DEPTH + 1);

   lei_pkg::rsp_type entry_ff [lei_pkg::RSP_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             take;

   assign empty = (count_ff == '0);
   assign occ   = count_ff;
   assign dout  = entry_ff[rd_ptr_ff];
   assign take  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(lei_pkg::RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PW'(lei_pkg::RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

FILE: tb/tb_line_edit_input_fifo.sv
// Self-checking testbench for the line editing input FIFO (echo, backspace, line reads).
// Depends on lei_pkg and line_edit_input_fifo; a shadow of the console buffer predicts results.
`timescale 1ns / 1ps

module tb_line_edit_input_fifo;

   localparam int BUF_DEPTH   = lei_pkg::DEPTH_DEFAULT;
   localparam int READ_MAX    = lei_pkg::MAX_READ_DEFAULT;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 16;
   localparam int HOLD_LEN    = 400;
   localparam int PHASE_ITEMS = 29;
   localparam int LONG_LINE   = 70;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   logic       clock = 1'b0;
   logic       reset;
   logic       push;
   logic       full;
   logic       req_mode;
   logic [7:0] req_char_in;
   logic [6:0] req_read_len;
   logic       empty;
   logic       pop;
   logic [2:0] rsp_kind;
   logic [7:0] rsp_data_byte;
   logic [9:0] rsp_fill_level;
   logic       rsp_line_ready;
   logic       rsp_last;

   // Shadow copy of the console buffer.
   logic [7:0] shadow_bytes [BUF_DEPTH];
   int         shadow_head;
   int         shadow_fill;
   logic       shadow_line;

   lei_pkg::rsp_type console_results_due [$];
   int         fail_count = 0;
   int         cycle_count = 0;
   int         sender_idle_pct = 0;
   int         receiver_stall_pct = 0;
   int         hold_cycles = 0;

   line_edit_input_fifo dut (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_mode      (req_mode),
      .req_char_in   (req_char_in),
      .req_read_len  (req_read_len),
      .empty         (empty),
      .pop           (pop),
      .rsp_kind      (rsp_kind),
      .rsp_data_byte (rsp_data_byte),
      .rsp_fill_level(rsp_fill_level),
      .rsp_line_ready(rsp_line_ready),
      .rsp_last      (rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // The receiver stalls at random, or holds off entirely while hold_cycles runs down.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      lei_pkg::rsp_type due;
      if (!reset && pop && !empty) begin
         if (console_results_due.size() == 0) begin
            $error("result transaction with nothing outstanding: kind %0d data %0h",
                   rsp_kind, rsp_data_byte);
            fail_count++;
         end else begin
            due = console_results_due.pop_front();
            if (rsp_kind !== due.kind) begin
               $error("kind: expected %0d, actual %0d", due.kind, rsp_kind);
               fail_count++;
            end
            if (rsp_data_byte !== due.data_byte) begin
               $error("data_byte: expected %0h, actual %0h", due.data_byte, rsp_data_byte);
               fail_count++;
            end
            if (rsp_fill_level !== due.fill_level) begin
               $error("fill_level: expected %0d, actual %0d", due.fill_level, rsp_fill_level);
               fail_count++;
            end
            if (rsp_line_ready !== due.line_ready) begin
               $error("line_ready: expected %0b, actual %0b", due.line_ready, rsp_line_ready);
               fail_count++;
            end
            if (rsp_last !== due.last) begin
               $error("last: expected %0b, actual %0b", due.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   function automatic void queue_result(lei_pkg::kind_type kind, logic [7:0] data,
                                        logic last);
      lei_pkg::rsp_type r;
      r.kind       = kind;
      r.data_byte  = data;
      r.fill_level = shadow_fill[9:0];
      r.line_ready = shadow_line;
      r.last       = last;
      console_results_due.push_back(r);
   endfunction

   // Applies one accepted transaction to the shadow buffer and queues what it emits.
   function automatic void console_apply(logic mode, logic [7:0] ch, logic [6:0] len);
      int take;
      if (mode == MODE_ADD) begin
         lei_pkg::kind_type kind;
         if (ch == lei_pkg::BACKSPACE_CODE) begin
            if (shadow_fill > 0) shadow_fill--;
            kind = lei_pkg::KIND_BACKSPACE;
         end else if (shadow_fill < BUF_DEPTH) begin
            shadow_bytes[(shadow_head + shadow_fill) % BUF_DEPTH] = ch;
            shadow_fill++;
            kind = lei_pkg::KIND_STORED;
         end else begin
            kind = lei_pkg::KIND_DROPPED;
         end
         if (ch == lei_pkg::NEWLINE_CODE) shadow_line = 1'b1;
         queue_result(kind, ch, 1'b1);
      end else if (len == 0) begin
         queue_result(lei_pkg::KIND_ZERO_LEN, 8'h00, 1'b1);
      end else if (shadow_fill == 0) begin
         shadow_line = 1'b0;
         queue_result(lei_pkg::KIND_EMPTY, 8'h00, 1'b1);
      end else begin
         take = (len > READ_MAX) ? READ_MAX : len;
         if (take > shadow_fill) take = shadow_fill;
         for (int i = 0; i < take; i++) begin
            logic [7:0] b;
            b = shadow_bytes[shadow_head];
            shadow_head = (shadow_head + 1) % BUF_DEPTH;
            shadow_fill--;
            queue_result(lei_pkg::KIND_DATA, b, i + 1 == take);
         end
      end
   endfunction

   task automatic send_item(input logic mode, input logic [7:0] ch, input logic [6:0] len);
      int gap;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < sender_idle_pct) gap++;
      repeat (gap) begin
         push <= 1'b0;
         req_mode <= 1'($urandom_range(1));
         req_char_in <= 8'($urandom_range(255));
         req_read_len <= 7'($urandom_range(64));
         @(posedge clock);
      end
      push <= 1'b1;
      req_mode <= mode;
      req_char_in <= ch;
      req_read_len <= len;
      do @(posedge clock); while (full);
      console_apply(mode, ch, len);
   endtask

   task automatic send_char(input logic [7:0] ch);
      send_item(MODE_ADD, ch, 7'($urandom_range(64)));
   endtask

   task automatic send_read(input logic [6:0] len);
      send_item(MODE_READ, 8'($urandom_range(255)), len);
   endtask

   // A character that is neither backspace nor newline.
   function automatic logic [7:0] plain_char();
      logic [7:0] ch;
      do ch = 8'($urandom_range(255));
      while (ch == lei_pkg::BACKSPACE_CODE || ch == lei_pkg::NEWLINE_CODE);
      return ch;
   endfunction

   task automatic send_random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) send_char(lei_pkg::BACKSPACE_CODE);
      else if (pick < 16) send_char(lei_pkg::NEWLINE_CODE);
      else if (pick < 64) send_char(plain_char());
      else if (pick < 68) send_read(7'd0);
      else if (pick < 88) send_read(7'($urandom_range(1, 8)));
      else if (pick < 96) send_read(7'($urandom_range(9, 63)));
      else send_read(7'd64);
   endtask

   task automatic test_empty_buffer();
      send_read(7'd1);
      send_read(7'd0);
      send_char(lei_pkg::BACKSPACE_CODE);
      send_char(lei_pkg::NEWLINE_CODE);
      send_read(7'd0);
      send_read(7'd64);
      send_read(7'd5);
   endtask

   task automatic test_line_editing();
      send_char(8'h00);
      send_char(8'hFF);
      send_char(8'h55);
      send_char(8'hAA);
      send_char(lei_pkg::BACKSPACE_CODE);
      send_char(lei_pkg::NEWLINE_CODE);
      send_read(7'd2);
      send_read(7'd64);
      send_read(7'd3);
      send_read(7'd0);
   endtask

   // Builds a line longer than one read, then drains it with oversized reads.
   task automatic test_long_line();
      repeat (LONG_LINE) send_char(plain_char());
      send_char(lei_pkg::NEWLINE_CODE);
      send_read(7'd127);
      send_read(7'd64);
      send_read(7'd64);
   endtask

   // The receiver holds off so that the result queue backs up and full rises.
   task automatic test_backpressure();
      hold_cycles = HOLD_LEN;
      repeat (24) send_random_item();
   endtask

   task automatic test_random_phases();
      int idle_sender [4]   = '{0, 53, 0, 18};
      int idle_receiver [4] = '{0, 0, 53, 18};
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = idle_sender[p];
         receiver_stall_pct = idle_receiver[p];
         repeat (PHASE_ITEMS) send_random_item();
      end
   endtask

   initial begin
      reset <= 1'b1;
      push <= 1'b0;
      pop <= 1'b0;
      req_mode <= MODE_ADD;
      req_char_in <= 8'h00;
      req_read_len <= 7'd0;
      shadow_head = 0;
      shadow_fill = 0;
      shadow_line = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct = 18;
      receiver_stall_pct = 18;
      test_empty_buffer();
      test_line_editing();
      test_long_line();
      test_backpressure();
      test_random_phases();

      push <= 1'b0;
      while (console_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
